>>> hdl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and codes of the streaming KMP matcher
// Holds the operation codes of the input item and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // Operation codes carried by the operation field of an input item.
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted input item
    logic decode;    // first step of the item, sets up any search
    logic fallback;  // mismatch: follow the failure link
    logic commit;    // search finished: update state, emit a result on a text match
  } kmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search;     // the decoded item needs a prefix search
    logic step_done;  // the current comparison ends the search
    logic hit;        // a text comparison completes a full match
    logic out_busy;   // the result register holds an untaken result
  } kmp_sts_t;

endpackage

>>> hdl/kmp_ram.sv
// ----------------------------------------------------------------------------
// kmp_ram: generic single-write, single-read RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl: sequencing controller of the streaming KMP matcher
// Accepts one item at a time and steps the datapath through decode, RAM
// fetch and compare cycles until the prefix search has finished.
// ----------------------------------------------------------------------------
module kmp_ctrl
  import kmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kmp_sts_t  sts,
  output kmp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          state_nxt    = S_DECODE;
          in_ready_nxt = 1'b0;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.search) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_FETCH: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!sts.step_done) begin
          cmd.fallback = 1'b1;
          state_nxt    = S_FETCH;
        end else if (!(sts.hit && sts.out_busy)) begin
          // A match waits here while the previous result is still untaken.
          cmd.commit   = 1'b1;
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

>>> hdl/kmp_dp.sv
// ----------------------------------------------------------------------------
// kmp_dp: datapath of the streaming KMP matcher
// Holds the pattern and failure-table RAMs, the matcher state, the captured
// input item and the result register, and acts on controller commands.
// ----------------------------------------------------------------------------
module kmp_dp
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_operation,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_match_start,
  input  kmp_cmd_t    cmd,
  output kmp_sts_t    sts
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

  // Captured input item.
  logic       op_r;
  logic [7:0] sym_r;
  logic       last_r;

  // Matcher state.
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     complete_r, complete_nxt;
  logic [LEN_W-1:0]         build_r, build_nxt;
  logic [LEN_W-1:0]         matched_r, matched_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]         k_r, k_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              out_start_r, out_start_nxt;

  // RAM ports.
  logic             pat_we;
  logic             fail_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] fail_wdata;
  logic [7:0]       pat_rdata;
  logic [IDX_W-1:0] fail_rdata;
  logic [LEN_W-1:0] k_dec;

  // Comparison and decode terms.
  logic             eq;
  logic [LEN_W-1:0] k_fin;
  logic             first_char;
  logic             search;
  logic             is_text;

  assign is_text    = (op_r == OP_TEXT);
  assign eq         = (pat_rdata == sym_r);
  assign k_fin      = k_r + LEN_W'(eq);
  assign k_dec      = k_r - LEN_ONE;
  assign first_char = complete_r || (len_r == '0);
  assign search     = is_text ? (complete_r && (len_r != '0))
                              : (!first_char && (len_r != LEN_FULL));

  assign sts.search    = search;
  assign sts.step_done = eq || (k_r == '0);
  assign sts.hit       = is_text && (k_fin == len_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  // The first pattern character is written at decode, the others that fit the store at commit.
  assign pat_we     = (!is_text && cmd.decode && first_char) || (!is_text && cmd.commit);
  assign fail_we    = pat_we;
  assign wr_addr    = cmd.decode ? '0 : len_r[IDX_W-1:0];
  assign fail_wdata = cmd.decode ? '0 : k_fin[IDX_W-1:0];

  kmp_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_MAX)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (wr_addr),
    .wdata (sym_r),
    .raddr (k_r[IDX_W-1:0]),
    .rdata (pat_rdata)
  );

  kmp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PATTERN_MAX)
  ) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (wr_addr),
    .wdata (fail_wdata),
    .raddr (k_dec[IDX_W-1:0]),
    .rdata (fail_rdata)
  );

  // Next-state logic for the matcher registers.
  always_comb begin
    len_nxt       = len_r;
    complete_nxt  = complete_r;
    build_nxt     = build_r;
    matched_nxt   = matched_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    out_start_nxt = out_start_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.decode) begin
      if (is_text) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
        if (search) begin
          k_nxt = (matched_r >= len_r) ? '0 : matched_r;
        end else begin
          matched_nxt = '0;
          if (last_r) begin
            pos_nxt = '0;
          end
        end
      end else begin
        // A pattern character after completion starts a new pattern.
        if (complete_r) begin
          len_nxt      = '0;
          complete_nxt = 1'b0;
          build_nxt    = '0;
          matched_nxt  = '0;
          pos_nxt      = '0;
        end
        if (first_char) begin
          len_nxt      = LEN_ONE;
          build_nxt    = '0;
          complete_nxt = last_r;
        end else if (len_r == LEN_FULL) begin
          // The store is full: the character is dropped, its mark still counts.
          complete_nxt = last_r;
        end else begin
          k_nxt = build_r;
        end
      end
    end

    if (cmd.fallback) begin
      k_nxt = LEN_W'(fail_rdata);
    end

    if (cmd.commit) begin
      if (is_text) begin
        if (sts.hit) begin
          // The failure value of the last pattern index equals the final build prefix.
          matched_nxt   = build_r;
          out_valid_nxt = 1'b1;
          out_start_nxt = 32'(pos_r - POSITION_BITS'(len_r) + POSITION_BITS'(1));
        end else begin
          matched_nxt = k_fin;
        end
        if (last_r) begin
          matched_nxt = '0;
          pos_nxt     = '0;
        end
      end else begin
        len_nxt      = len_r + LEN_ONE;
        build_nxt    = k_fin;
        complete_nxt = last_r;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      complete_r  <= 1'b0;
      build_r     <= '0;
      matched_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      complete_r  <= complete_nxt;
      build_r     <= build_nxt;
      matched_r   <= matched_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    k_r         <= k_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;

endmodule

>>> hdl/kmp_stream_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core: streaming Knuth-Morris-Pratt string search
// Builds the failure table while pattern characters arrive, then scans text
// characters and reports the 1-based start position of every match.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that needs no prefix search (the
// first pattern character, a character beyond the pattern store, or text
// while no pattern is complete) passes through the decode state only before
// the block is ready again. Any other item then runs a fetch and a compare
// state for its first comparison and one more such pair for each of its F
// failure-link steps: the fetch state presents the address to the pattern
// and failure RAMs and the compare state compares their registered read
// data. Over a text, F averages at most one per character. A match result
// waits in an output register; a further match stalls in the compare cycle
// only while that register is still untaken. There is no clearing pass after reset.
module kmp_stream_matcher_core
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_match_start
);

  kmp_cmd_t cmd;
  kmp_sts_t sts;

  // Controller.
  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath with the pattern and failure-table RAMs.
  kmp_dp #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start),
    .cmd             (cmd),
    .sts             (sts)
  );

`ifndef SYNTHESIS
  // At most one command is issued in any cycle.
  a_cmd_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.decode, cmd.fallback, cmd.commit}))
    else $error("more than one datapath command in a cycle");

  // A match is never committed over a result that is still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.hit) |-> !sts.out_busy)
    else $error("match committed while the result register is busy");

  // An accepted transaction is decoded in the following cycle.
  a_load_decode : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.decode && !in_ready))
    else $error("accepted transaction not decoded");

  // After a commit the block is ready for the next transaction.
  a_commit_ready : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ready)
    else $error("block not ready after commit");
`endif

endmodule
